@@ rtl/stld_pkg.sv @@
package stld_pkg;

	localparam int LIN_MAX_W  = 25;
	localparam int COEF_W     = 17;
	localparam int TINY_SCALE = 1000;
	localparam int DRV_W      = 8;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pixel_t;

	typedef struct packed {
		logic [7:0] red_drive;
		logic [7:0] green_drive;
		logic [7:0] blue_drive;
	} drive_t;

	typedef logic [LIN_MAX_W-1:0] lin_rom_t [256];
	typedef logic signed [COEF_W-1:0] coef_t [3][3];

	localparam coef_t COEF = '{
		'{17'sd25648, 17'sd14980, 17'sd1208},
		'{17'sd1789,  17'sd34228, -17'sd63},
		'{17'sd185,   -17'sd111,  17'sd14511}
	};

	function automatic longint unsigned pow5_q30(longint unsigned r);
		longint unsigned p;
		p = r;
		for (int k = 0; k < 4; k++) begin
			p = (p * r) >> 30;
		end
		return p;
	endfunction

	function automatic longint unsigned lin_value(int f, int c);
		longint unsigned num, q, b2, lo, hi, mid, v;
		if (c <= 10) begin
			num = (longint'(10 * c) << f) + 16473;
			return num / 32946;
		end
		num = 1000 * longint'(c) + 14025;
		q   = (num << 30) / 269025;
		b2  = (q * q) >> 30;
		lo  = 0;
		hi  = longint'(1) << 30;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			if (pow5_q30(mid) <= b2) begin
				lo = mid;
			end else begin
				hi = mid - 1;
			end
		end
		v = (b2 * lo) >> 30;
		v = (v + (longint'(1) << (29 - f))) >> (30 - f);
		return v;
	endfunction

	function automatic lin_rom_t build_lin_rom(int f);
		lin_rom_t rom;
		for (int c = 0; c < 256; c++) begin
			rom[c] = LIN_MAX_W'(lin_value(f, c));
		end
		return rom;
	endfunction

endpackage

@@ rtl/stld_div.sv @@
module stld_div #(
	parameter int MW = 34
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [MW+7:0]        num,
	input  logic [MW-1:0]        den,
	output logic                 out_valid,
	output logic [7:0]           quo
);
	import stld_pkg::*;

	localparam int NW = MW + DRV_W;

	logic          vld_s [DRV_W];
	logic [NW-1:0] rem_s [DRV_W];
	logic [MW-1:0] den_s [DRV_W];
	logic [7:0]    quo_s [DRV_W];

	for (genvar g = 0; g < DRV_W; g++) begin : g_stage
		logic          vld_p;
		logic [NW-1:0] rem_p;
		logic [MW-1:0] den_p;
		logic [7:0]    quo_p;
		logic [NW-1:0] trial;
		logic          ge;

		if (g == 0) begin : g_first
			assign vld_p = in_valid;
			assign rem_p = num;
			assign den_p = den;
			assign quo_p = '0;
		end else begin : g_next
			assign vld_p = vld_s[g-1];
			assign rem_p = rem_s[g-1];
			assign den_p = den_s[g-1];
			assign quo_p = quo_s[g-1];
		end

		assign trial = NW'(den_p) << (DRV_W - 1 - g);
		assign ge    = rem_p >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else begin
				vld_s[g] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g] <= ge ? rem_p - trial : rem_p;
			den_s[g] <= den_p;
			quo_s[g] <= quo_p | (ge ? 8'(1) << (DRV_W - 1 - g) : 8'd0);
		end
	end

	assign out_valid = vld_s[DRV_W-1];
	assign quo       = quo_s[DRV_W-1];

endmodule

@@ rtl/srgb_to_led_drive.sv @@
// Channel  | Signals                 | Beat
// ---------+-------------------------+-----------------------------------
// pixel    | start, busy, pixel      | start high and busy low at a clock edge
// drive    | done, drive             | done high for one cycle
// config   | cfg_we, cfg_wdata       | cfg_we high at a clock edge
//
// One pixel per cycle; each result passes through the ROM, products, sums, maximum,
// ratio setup and eight restoring divide stages.
// busy stays low: the pipeline never stalls and the receiver cannot stall.
// Reset clears all valid bits and sets brightness to 255.
module srgb_to_led_drive #(
	parameter int LINEAR_FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  stld_pkg::pixel_t  pixel,
	output logic              done,
	output stld_pkg::drive_t  drive,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata
);
	import stld_pkg::*;

	localparam int LIN_W = LINEAR_FRAC_BITS + 1;
	localparam int SUM_W = LINEAR_FRAC_BITS + COEF_W + 2;
	localparam int MW    = SUM_W - 1;
	localparam int LAT   = 5 + DRV_W;
	localparam lin_rom_t LIN_ROM = build_lin_rom(LINEAR_FRAC_BITS);

	logic [7:0] br_q;

	logic                    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [LIN_W-1:0]        lin_s1 [3];
	logic signed [SUM_W-1:0] prod_s2 [3][3];
	logic signed [SUM_W-1:0] sum_s3 [3];
	logic signed [SUM_W-1:0] sum_s4 [3];
	logic signed [SUM_W-1:0] max_s4;
	logic [MW+7:0]           num_s5 [3];
	logic [MW-1:0]           den_s5 [3];

	logic [7:0]              chan [3];
	logic signed [SUM_W-1:0] max_c;
	logic                    dv_vld [3];
	logic [7:0]              dv_quo [3];

	assign busy = 1'b0;
	assign chan[0] = pixel.red_in;
	assign chan[1] = pixel.green_in;
	assign chan[2] = pixel.blue_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			br_q   <= 8'd255;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (cfg_we) begin
				br_q <= cfg_wdata;
			end
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_comb begin
		max_c = sum_s3[0];
		if (sum_s3[1] > max_c) begin
			max_c = sum_s3[1];
		end
		if (sum_s3[2] > max_c) begin
			max_c = sum_s3[2];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			lin_s1[i] <= LIN_ROM[chan[i]][LIN_W-1:0];
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_s2[i][j] <= SUM_W'(COEF[i][j] * $signed({1'b0, lin_s1[j]}));
			end
		end
		for (int i = 0; i < 3; i++) begin
			sum_s3[i] <= prod_s2[i][0] + prod_s2[i][1] + prod_s2[i][2];
		end
		sum_s4 <= sum_s3;
		max_s4 <= max_c;
	end

	for (genvar i = 0; i < 3; i++) begin : g_chan
		logic [MW-1:0]  s, m;
		logic           pos, tiny;

		assign s    = sum_s4[i][MW-1:0];
		assign m    = max_s4[MW-1:0];
		assign pos  = (max_s4 > 0) && (sum_s4[i] > 0);
		assign tiny = ((MW+10)'(s) * (MW+10)'(TINY_SCALE)) < (MW+10)'(m);

		always_ff @(posedge clk) begin
			if (pos && !tiny) begin
				num_s5[i] <= (MW+8)'(s) * (MW+8)'(br_q);
				den_s5[i] <= m;
			end else begin
				num_s5[i] <= '0;
				den_s5[i] <= MW'(1);
			end
		end

		stld_div #(.MW(MW)) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld_s5),
			.num       (num_s5[i]),
			.den       (den_s5[i]),
			.out_valid (dv_vld[i]),
			.quo       (dv_quo[i])
		);
	end

	assign done              = dv_vld[0];
	assign drive.red_drive   = dv_quo[0];
	assign drive.green_drive = dv_quo[1];
	assign drive.blue_drive  = dv_quo[2];

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("result missing");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##LAT !done)
		else $error("unexpected result");

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_vld[0] == dv_vld[1]) && (dv_vld[1] == dv_vld[2]))
		else $error("divider lanes out of step");

endmodule
